>>> rtl/cfsg_pkg.sv
// Shared types, widths and codes for the camera frame strobe generator.
`default_nettype none

package cfsg_pkg;

    localparam int SCAN_W     = 24;  // scan counter and 24-bit registers
    localparam int FCNT_W     = 16;  // frame_count
    localparam int PREHEAT_W  = 8;   // preheat_frames
    localparam int MARGIN_W   = 10;  // pre/post margins, up to 1023
    localparam int TRIG_W     = 8;   // trigger width, up to 255
    localparam int FRAME_W    = 18;  // signed frame index, -256 .. 65534
    localparam int FS_W       = 34;  // signed frame start position
    localparam int AFTER_W    = 25;  // active plus post margin
    localparam int NUM_W      = 27;  // signed numerator of the frame solve
    localparam int DIV_W      = 25;  // magnitude and quotient of the solve
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int NUM_WIN = 3;
    localparam logic [1:0] WIN_LAMP = 2'd0;
    localparam logic [1:0] WIN_SHUT = 2'd1;
    localparam logic [1:0] WIN_TRIG = 2'd2;

    localparam logic SLOT_ORIGIN  = 1'b0;  // state for scan zero
    localparam logic SLOT_CURRENT = 1'b1;  // state for the scan counter

    localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FCOUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PREHEAT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGEA  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 3'd6;

    localparam logic [SCAN_W-1:0]    RST_START   = 24'd0;
    localparam logic [SCAN_W-1:0]    RST_PERIOD  = 24'd1000;
    localparam logic [SCAN_W-1:0]    RST_ACTIVE  = 24'd100;
    localparam logic [FCNT_W-1:0]    RST_FCOUNT  = 16'd0;
    localparam logic [PREHEAT_W-1:0] RST_PREHEAT = 8'd0;
    localparam logic                 RST_TRIGEA  = 1'b0;
    localparam logic [SCAN_W-1:0]    RST_TOTAL   = 24'd0;

    localparam int DEF_ILLUM_PRE    = 10;
    localparam int DEF_ILLUM_POST   = 10;
    localparam int DEF_SHUTTER_PRE  = 10;
    localparam int DEF_SHUTTER_POST = 10;
    localparam int DEF_TRIG_WIDTH   = 10;

    typedef struct packed {
        logic [SCAN_W-1:0]    start;
        logic [SCAN_W-1:0]    period;
        logic [SCAN_W-1:0]    active;
        logic [FCNT_W-1:0]    frame_count;
        logic [PREHEAT_W-1:0] preheat;
        logic                 trig_each;
        logic [SCAN_W-1:0]    total;
    } cfg_t;

    // One timing window: frames lo .. hi_m1, on from start - lead to start + after.
    typedef struct packed {
        logic                       empty;
        logic signed [FRAME_W-1:0]  lo;
        logic signed [FRAME_W-1:0]  hi_m1;
        logic [MARGIN_W-1:0]        lead;
        logic [AFTER_W-1:0]         after;
    } win_cfg_t;

    typedef struct packed {
        logic                       valid;
        logic                       slot;
        logic [1:0]                 win;
        logic signed [FRAME_W-1:0]  k;
        logic signed [FS_W-1:0]     fs;
    } load_t;

    typedef enum logic [2:0] {
        SOLVE_IDLE,
        SOLVE_LOAD,
        SOLVE_DIV,
        SOLVE_CLAMP,
        SOLVE_MUL,
        SOLVE_STORE
    } solve_state_t;

endpackage

`default_nettype wire

>>> rtl/cfsg_regs.sv
// Configuration registers and the derived per-window frame ranges and margins.
`default_nettype none

module cfsg_regs #(
    parameter int ILLUM_PRE_SCANS    = cfsg_pkg::DEF_ILLUM_PRE,
    parameter int ILLUM_POST_SCANS   = cfsg_pkg::DEF_ILLUM_POST,
    parameter int SHUTTER_PRE_SCANS  = cfsg_pkg::DEF_SHUTTER_PRE,
    parameter int SHUTTER_POST_SCANS = cfsg_pkg::DEF_SHUTTER_POST,
    parameter int TRIGGER_WIDTH      = cfsg_pkg::DEF_TRIG_WIDTH
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [cfsg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [cfsg_pkg::CFG_DATA_W-1:0]        cfg_data,
    output cfsg_pkg::cfg_t                              cfg,
    output cfsg_pkg::win_cfg_t [cfsg_pkg::NUM_WIN-1:0]  win_cfg
);

    cfsg_pkg::cfg_t cfg_reg;

    logic signed [cfsg_pkg::FRAME_W-1:0] fc_m1;
    logic signed [cfsg_pkg::FRAME_W-1:0] lamp_lo;
    logic signed [cfsg_pkg::FRAME_W-1:0] trig_hi_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start       <= cfsg_pkg::RST_START;
            cfg_reg.period      <= cfsg_pkg::RST_PERIOD;
            cfg_reg.active      <= cfsg_pkg::RST_ACTIVE;
            cfg_reg.frame_count <= cfsg_pkg::RST_FCOUNT;
            cfg_reg.preheat     <= cfsg_pkg::RST_PREHEAT;
            cfg_reg.trig_each   <= cfsg_pkg::RST_TRIGEA;
            cfg_reg.total       <= cfsg_pkg::RST_TOTAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfsg_pkg::REG_START:   cfg_reg.start       <= cfg_data;
                cfsg_pkg::REG_PERIOD:  cfg_reg.period      <= cfg_data;
                cfsg_pkg::REG_ACTIVE:  cfg_reg.active      <= cfg_data;
                cfsg_pkg::REG_FCOUNT:  cfg_reg.frame_count <= cfg_data[cfsg_pkg::FCNT_W-1:0];
                cfsg_pkg::REG_PREHEAT: cfg_reg.preheat     <= cfg_data[cfsg_pkg::PREHEAT_W-1:0];
                cfsg_pkg::REG_TRIGEA:  cfg_reg.trig_each   <= cfg_data[0];
                cfsg_pkg::REG_TOTAL:   cfg_reg.total       <= cfg_data;
                default:               cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

    always_comb
    begin
        fc_m1   = $signed({2'b00, cfg_reg.frame_count}) - 18'sd1;
        lamp_lo = -$signed({10'd0, cfg_reg.preheat});
        // trigger frames: all real frames, or frame zero alone
        if (cfg_reg.trig_each || cfg_reg.frame_count == '0)
            trig_hi_m1 = fc_m1;
        else
            trig_hi_m1 = '0;

        win_cfg[cfsg_pkg::WIN_LAMP].lo     = lamp_lo;
        win_cfg[cfsg_pkg::WIN_LAMP].hi_m1  = fc_m1;
        win_cfg[cfsg_pkg::WIN_LAMP].empty  = lamp_lo > fc_m1;
        win_cfg[cfsg_pkg::WIN_LAMP].lead   = cfsg_pkg::MARGIN_W'(ILLUM_PRE_SCANS);
        win_cfg[cfsg_pkg::WIN_LAMP].after  = {1'b0, cfg_reg.active}
                                           + cfsg_pkg::AFTER_W'(ILLUM_POST_SCANS);

        win_cfg[cfsg_pkg::WIN_SHUT].lo     = '0;
        win_cfg[cfsg_pkg::WIN_SHUT].hi_m1  = fc_m1;
        win_cfg[cfsg_pkg::WIN_SHUT].empty  = cfg_reg.frame_count == '0;
        win_cfg[cfsg_pkg::WIN_SHUT].lead   = cfsg_pkg::MARGIN_W'(SHUTTER_PRE_SCANS);
        win_cfg[cfsg_pkg::WIN_SHUT].after  = {1'b0, cfg_reg.active}
                                           + cfsg_pkg::AFTER_W'(SHUTTER_POST_SCANS);

        win_cfg[cfsg_pkg::WIN_TRIG].lo     = '0;
        win_cfg[cfsg_pkg::WIN_TRIG].hi_m1  = trig_hi_m1;
        win_cfg[cfsg_pkg::WIN_TRIG].empty  = cfg_reg.frame_count == '0;
        win_cfg[cfsg_pkg::WIN_TRIG].lead   = '0;
        win_cfg[cfsg_pkg::WIN_TRIG].after  = cfsg_pkg::AFTER_W'(TRIGGER_WIDTH);
    end

endmodule

`default_nettype wire

>>> rtl/cfsg_solver.sv
// Sequencer that solves the frame index and frame start of every window after a register write.
`default_nettype none

module cfsg_solver (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic [cfsg_pkg::SCAN_W-1:0]            scan_count,
    input  wire cfsg_pkg::cfg_t                         cfg,
    input  wire cfsg_pkg::win_cfg_t [cfsg_pkg::NUM_WIN-1:0] win_cfg,
    output logic                                        busy,
    output cfsg_pkg::load_t                             load
);

    cfsg_pkg::solve_state_t state_reg;
    cfsg_pkg::solve_state_t state_next;

    logic                                 slot_reg;
    logic [1:0]                           win_reg;
    logic                                 neg_reg;
    logic [cfsg_pkg::DIV_W-1:0]           quo_reg;
    logic [cfsg_pkg::SCAN_W-1:0]          rem_reg;
    logic [cfsg_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic signed [cfsg_pkg::FRAME_W-1:0]  k_reg;
    logic signed [cfsg_pkg::FS_W-1:0]     prod_reg;

    cfsg_pkg::win_cfg_t                   wc;
    logic [cfsg_pkg::SCAN_W-1:0]          pos;
    logic signed [cfsg_pkg::NUM_W-1:0]    num;
    logic signed [cfsg_pkg::NUM_W-1:0]    num_neg;
    logic [cfsg_pkg::NUM_W-1:0]           mag_wide;
    logic [cfsg_pkg::DIV_W-1:0]           mag;
    logic [cfsg_pkg::DIV_W-1:0]           r_sh;
    logic                                 r_ge;
    logic [cfsg_pkg::DIV_W-1:0]           r_diff;
    logic signed [cfsg_pkg::DIV_W:0]      q_signed;
    logic signed [cfsg_pkg::FRAME_W-1:0]  lo_m1;
    logic signed [cfsg_pkg::FRAME_W-1:0]  k_next;
    logic signed [cfsg_pkg::FRAME_W+cfsg_pkg::SCAN_W:0] product;
    logic                                 last_job;
    logic                                 per_zero;

    always_comb
    begin
        case (win_reg)
            cfsg_pkg::WIN_LAMP: wc = win_cfg[cfsg_pkg::WIN_LAMP];
            cfsg_pkg::WIN_SHUT: wc = win_cfg[cfsg_pkg::WIN_SHUT];
            cfsg_pkg::WIN_TRIG: wc = win_cfg[cfsg_pkg::WIN_TRIG];
            default:            wc = '0;
        endcase
    end

    assign per_zero = cfg.period == '0;
    assign pos      = (slot_reg == cfsg_pkg::SLOT_CURRENT) ? scan_count : '0;
    assign last_job = (slot_reg == cfsg_pkg::SLOT_CURRENT) && (win_reg == cfsg_pkg::WIN_TRIG);

    // floor((pos + lead - start) / period), negative side as a ceiling of the magnitude
    always_comb
    begin
        num      = $signed({3'b000, pos}) + $signed({17'd0, wc.lead})
                 - $signed({3'b000, cfg.start});
        num_neg  = -num;
        if (num[cfsg_pkg::NUM_W-1])
            mag_wide = num_neg + {3'b000, cfg.period} - 27'd1;
        else
            mag_wide = num;
        mag      = mag_wide[cfsg_pkg::DIV_W-1:0];
    end

    // one quotient bit per cycle
    always_comb
    begin
        r_sh   = {rem_reg, quo_reg[cfsg_pkg::DIV_W-1]};
        r_ge   = r_sh >= {1'b0, cfg.period};
        r_diff = r_sh - {1'b0, cfg.period};
    end

    always_comb
    begin
        if (neg_reg)
            q_signed = -$signed({1'b0, quo_reg});
        else
            q_signed = $signed({1'b0, quo_reg});
        lo_m1 = wc.lo - 18'sd1;
        if (per_zero)
            k_next = wc.hi_m1;
        else if (q_signed < lo_m1)
            k_next = lo_m1;
        else if (q_signed > wc.hi_m1)
            k_next = wc.hi_m1;
        else
            k_next = q_signed[cfsg_pkg::FRAME_W-1:0];
    end

    assign product = k_reg * $signed({1'b0, cfg.period});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfsg_pkg::SOLVE_IDLE:  state_next = cfsg_pkg::SOLVE_IDLE;
            cfsg_pkg::SOLVE_LOAD:  state_next = per_zero ? cfsg_pkg::SOLVE_CLAMP
                                                         : cfsg_pkg::SOLVE_DIV;
            cfsg_pkg::SOLVE_DIV:
            begin
                if (cnt_reg == cfsg_pkg::DIV_CNT_W'(cfsg_pkg::DIV_W - 1))
                    state_next = cfsg_pkg::SOLVE_CLAMP;
            end
            cfsg_pkg::SOLVE_CLAMP: state_next = cfsg_pkg::SOLVE_MUL;
            cfsg_pkg::SOLVE_MUL:   state_next = cfsg_pkg::SOLVE_STORE;
            cfsg_pkg::SOLVE_STORE: state_next = last_job ? cfsg_pkg::SOLVE_IDLE
                                                         : cfsg_pkg::SOLVE_LOAD;
            default:               state_next = cfsg_pkg::SOLVE_IDLE;
        endcase
        // a new register write restarts the whole solve
        if (start)
            state_next = cfsg_pkg::SOLVE_LOAD;
    end

    always_comb
    begin
        busy       = state_reg != cfsg_pkg::SOLVE_IDLE;
        load.valid = state_reg == cfsg_pkg::SOLVE_STORE;
        load.slot  = slot_reg;
        load.win   = win_reg;
        load.k     = k_reg;
        load.fs    = $signed({10'd0, cfg.start}) + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cfsg_pkg::SOLVE_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= cfsg_pkg::SLOT_ORIGIN;
            win_reg  <= cfsg_pkg::WIN_LAMP;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            slot_reg <= cfsg_pkg::SLOT_ORIGIN;
            win_reg  <= cfsg_pkg::WIN_LAMP;
        end
        else
        begin
            case (state_reg)
                cfsg_pkg::SOLVE_LOAD:  cnt_reg <= '0;
                cfsg_pkg::SOLVE_DIV:   cnt_reg <= cnt_reg + 1'b1;
                cfsg_pkg::SOLVE_STORE:
                begin
                    if (win_reg == cfsg_pkg::WIN_TRIG)
                    begin
                        win_reg  <= cfsg_pkg::WIN_LAMP;
                        slot_reg <= cfsg_pkg::SLOT_CURRENT;
                    end
                    else
                        win_reg <= win_reg + 2'd1;
                end
                default:               cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            cfsg_pkg::SOLVE_LOAD:
            begin
                quo_reg <= mag;
                rem_reg <= '0;
                neg_reg <= num[cfsg_pkg::NUM_W-1];
            end
            cfsg_pkg::SOLVE_DIV:
            begin
                quo_reg <= {quo_reg[cfsg_pkg::DIV_W-2:0], r_ge};
                rem_reg <= r_ge ? r_diff[cfsg_pkg::SCAN_W-1:0] : r_sh[cfsg_pkg::SCAN_W-1:0];
            end
            cfsg_pkg::SOLVE_CLAMP: k_reg    <= k_next;
            cfsg_pkg::SOLVE_MUL:   prod_reg <= product[cfsg_pkg::FS_W-1:0];
            default:               k_reg    <= k_reg;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/cfsg_window.sv
// One timing window: tracks the governing frame scan by scan and flags a hit.
`default_nettype none

module cfsg_window (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cfsg_pkg::win_cfg_t           wcfg,
    input  wire logic [cfsg_pkg::SCAN_W-1:0]  period,
    input  wire logic                         load_en,
    input  wire cfsg_pkg::load_t              load,
    input  wire logic                         step,
    input  wire logic                         restart,
    input  wire logic                         wrap,
    input  wire logic [cfsg_pkg::SCAN_W-1:0]  pos,
    output logic                              hit
);

    // origin: state for scan zero; current: state for the scan counter
    logic signed [cfsg_pkg::FRAME_W-1:0] k_org_reg;
    logic signed [cfsg_pkg::FS_W-1:0]    fs_org_reg;
    logic signed [cfsg_pkg::FRAME_W-1:0] k_cur_reg;
    logic signed [cfsg_pkg::FS_W-1:0]    fs_cur_reg;

    logic signed [cfsg_pkg::FRAME_W-1:0] k_sel;
    logic signed [cfsg_pkg::FS_W-1:0]    fs_sel;
    logic signed [cfsg_pkg::FS_W-1:0]    p_ext;
    logic signed [cfsg_pkg::FS_W-1:0]    p_early;
    logic signed [cfsg_pkg::FS_W-1:0]    fs_end;
    logic signed [cfsg_pkg::FS_W-1:0]    fs_nxt;
    logic                                adv;
    logic signed [cfsg_pkg::FRAME_W-1:0] k_next;
    logic signed [cfsg_pkg::FS_W-1:0]    fs_next;

    always_comb
    begin
        k_sel   = restart ? k_org_reg : k_cur_reg;
        fs_sel  = restart ? fs_org_reg : fs_cur_reg;
        p_ext   = $signed({10'd0, pos});
        p_early = p_ext + $signed({24'd0, wcfg.lead});
        fs_end  = fs_sel + $signed({9'd0, wcfg.after});
        fs_nxt  = fs_sel + $signed({10'd0, period});

        hit = !wcfg.empty && (k_sel >= wcfg.lo) && (fs_sel <= p_early) && (p_ext < fs_end);

        // next frame becomes governing once its early edge is reached
        adv = (period != '0) && (k_sel < wcfg.hi_m1) && (p_early + 34'sd1 >= fs_nxt);

        if (wrap)
        begin
            k_next  = k_org_reg;
            fs_next = fs_org_reg;
        end
        else if (adv)
        begin
            k_next  = k_sel + 18'sd1;
            fs_next = fs_nxt;
        end
        else
        begin
            k_next  = k_sel;
            fs_next = fs_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_org_reg  <= '0;
            fs_org_reg <= '0;
            k_cur_reg  <= '0;
            fs_cur_reg <= '0;
        end
        else if (load_en)
        begin
            if (load.slot == cfsg_pkg::SLOT_ORIGIN)
            begin
                k_org_reg  <= load.k;
                fs_org_reg <= load.fs;
            end
            else
            begin
                k_cur_reg  <= load.k;
                fs_cur_reg <= load.fs;
            end
        end
        else if (step)
        begin
            k_cur_reg  <= k_next;
            fs_cur_reg <= fs_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/camera_frame_strobe_generator.sv
// Top level: scan counter, window lanes, register file, solver and result register.
//
// One input beat per scan (restart clears the scan position first); one result
// beat per input beat carrying lamp, shutter and trigger levels, the scan
// position and record_done. Both channels use valid/stall.
// The result beat is registered in the cycle after its input beat, and a new
// beat is taken every cycle unless item_stall is high: each window lane steps
// its frame index and frame start by at most one frame per scan, so one add and
// compare per lane sits between the state registers and the result register.
// A register write (cfg_we) starts the frame solver, which works out the
// governing frame of each of the three windows for scan zero and for the
// current scan counter with a one-bit-per-cycle divider in six solves (the
// divide is skipped with a zero period). item_stall is high meanwhile.
// After reset the registers hold their reset values, the scan counter is zero
// and no solve is needed. When the result side stalls, the result register
// holds and item_stall follows result_stall, so no beat is lost.
`default_nettype none

module camera_frame_strobe_generator #(
    parameter int ILLUM_PRE_SCANS    = cfsg_pkg::DEF_ILLUM_PRE,
    parameter int ILLUM_POST_SCANS   = cfsg_pkg::DEF_ILLUM_POST,
    parameter int SHUTTER_PRE_SCANS  = cfsg_pkg::DEF_SHUTTER_PRE,
    parameter int SHUTTER_POST_SCANS = cfsg_pkg::DEF_SHUTTER_POST,
    parameter int TRIGGER_WIDTH      = cfsg_pkg::DEF_TRIG_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [cfsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cfsg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire logic                               restart,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic                                    lamp_on,
    output logic                                    shutter_open,
    output logic                                    trigger_high,
    output logic [cfsg_pkg::SCAN_W-1:0]             scan_position,
    output logic                                    record_done
);

    cfsg_pkg::cfg_t                              cfg;
    cfsg_pkg::win_cfg_t [cfsg_pkg::NUM_WIN-1:0]  win_cfg;
    cfsg_pkg::load_t                             load;
    logic                                        solver_busy;

    logic [cfsg_pkg::SCAN_W-1:0] scan_reg;
    logic                        valid_reg;
    logic                        lamp_reg;
    logic                        shut_reg;
    logic                        trig_reg;
    logic [cfsg_pkg::SCAN_W-1:0] pos_reg;
    logic                        done_reg;

    logic                        accept;
    logic [cfsg_pkg::SCAN_W-1:0] pos;
    logic                        wrap;
    logic                        lamp_hit;
    logic                        shut_hit;
    logic                        trig_hit;
    logic                        win_gate;
    logic                        trig_gate;

    cfsg_regs #(
        .ILLUM_PRE_SCANS    (ILLUM_PRE_SCANS),
        .ILLUM_POST_SCANS   (ILLUM_POST_SCANS),
        .SHUTTER_PRE_SCANS  (SHUTTER_PRE_SCANS),
        .SHUTTER_POST_SCANS (SHUTTER_POST_SCANS),
        .TRIGGER_WIDTH      (TRIGGER_WIDTH)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .win_cfg   (win_cfg)
    );

    cfsg_solver u_solver (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cfg_we),
        .scan_count (scan_reg),
        .cfg        (cfg),
        .win_cfg    (win_cfg),
        .busy       (solver_busy),
        .load       (load)
    );

    assign item_stall = solver_busy || (valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;
    assign pos        = restart ? '0 : scan_reg;
    assign wrap       = pos == '1;

    cfsg_window u_lamp (
        .clk     (clk),
        .rst_n   (rst_n),
        .wcfg    (win_cfg[cfsg_pkg::WIN_LAMP]),
        .period  (cfg.period),
        .load_en (load.valid && load.win == cfsg_pkg::WIN_LAMP),
        .load    (load),
        .step    (accept),
        .restart (restart),
        .wrap    (wrap),
        .pos     (pos),
        .hit     (lamp_hit)
    );

    cfsg_window u_shut (
        .clk     (clk),
        .rst_n   (rst_n),
        .wcfg    (win_cfg[cfsg_pkg::WIN_SHUT]),
        .period  (cfg.period),
        .load_en (load.valid && load.win == cfsg_pkg::WIN_SHUT),
        .load    (load),
        .step    (accept),
        .restart (restart),
        .wrap    (wrap),
        .pos     (pos),
        .hit     (shut_hit)
    );

    cfsg_window u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .wcfg    (win_cfg[cfsg_pkg::WIN_TRIG]),
        .period  (cfg.period),
        .load_en (load.valid && load.win == cfsg_pkg::WIN_TRIG),
        .load    (load),
        .step    (accept),
        .restart (restart),
        .wrap    (wrap),
        .pos     (pos),
        .hit     (trig_hit)
    );

    // lamp and shutter stop two scans before the record end, trigger at the end
    assign win_gate  = ({1'b0, pos} + 25'd2) < {1'b0, cfg.total};
    assign trig_gate = pos < cfg.total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            scan_reg  <= pos + 1'b1;
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lamp_reg <= lamp_hit && win_gate;
            shut_reg <= shut_hit && win_gate;
            trig_reg <= trig_hit && trig_gate;
            pos_reg  <= pos;
            done_reg <= !trig_gate;
        end
    end

    assign result_valid  = valid_reg;
    assign lamp_on       = lamp_reg;
    assign shutter_open  = shut_reg;
    assign trigger_high  = trig_reg;
    assign scan_position = pos_reg;
    assign record_done   = done_reg;

    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg && pos_reg == $past(pos))
        else $error("accepted beat did not reach the result register");

    a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> scan_reg == $past(pos) + 1'b1)
        else $error("scan counter did not advance past the emitted scan");

    a_no_beat_while_solving: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> solver_busy && !accept)
        else $error("beat taken while frame solve pending");

    a_levels_before_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (lamp_reg || shut_reg || trig_reg) |-> !done_reg)
        else $error("line level high after record end");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for camera_frame_strobe_generator: per-scan strobe prediction and checks.
`timescale 1ns / 1ps

module testbench;

    // index outside the register list: a write there changes nothing
    localparam logic [cfsg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic                        lamp;
        logic                        shut;
        logic                        trig;
        logic [cfsg_pkg::SCAN_W-1:0] pos;
        logic                        done;
    } strobe_t;

    class strobe_scoreboard;
        cfsg_pkg::cfg_t              cfg;
        logic [cfsg_pkg::SCAN_W-1:0] scan_cnt;
        strobe_t                     expected_strobes[$];
        int                          errors;

        function new();
            cfg.start       = cfsg_pkg::RST_START;
            cfg.period      = cfsg_pkg::RST_PERIOD;
            cfg.active      = cfsg_pkg::RST_ACTIVE;
            cfg.frame_count = cfsg_pkg::RST_FCOUNT;
            cfg.preheat     = cfsg_pkg::RST_PREHEAT;
            cfg.trig_each   = cfsg_pkg::RST_TRIGEA;
            cfg.total       = cfsg_pkg::RST_TOTAL;
            scan_cnt        = '0;
            errors          = 0;
        endfunction

        function void write_reg(logic [cfsg_pkg::CFG_IDX_W-1:0] idx,
                                logic [cfsg_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                cfsg_pkg::REG_START:   cfg.start       = data;
                cfsg_pkg::REG_PERIOD:  cfg.period      = data;
                cfsg_pkg::REG_ACTIVE:  cfg.active      = data;
                cfsg_pkg::REG_FCOUNT:  cfg.frame_count = data[cfsg_pkg::FCNT_W-1:0];
                cfsg_pkg::REG_PREHEAT: cfg.preheat     = data[cfsg_pkg::PREHEAT_W-1:0];
                cfsg_pkg::REG_TRIGEA:  cfg.trig_each   = data[0];
                cfsg_pkg::REG_TOTAL:   cfg.total       = data;
                default:               ;
            endcase
        endfunction

        // Only the governing frame (latest start at or before p + lead) is tested.
        function bit frame_window(longint p, longint lo_n, longint hi_n,
                                  longint lead, longint after);
            longint s;
            longint per;
            longint n;
            longint num;
            longint q;
            longint fs;
            s   = longint'(cfg.start);
            per = longint'(cfg.period);
            if (lo_n >= hi_n)
                return 1'b0;
            if (per == 0)
                n = hi_n - 1;
            else
            begin
                num = p + lead - s;
                if (num >= 0)
                    q = num / per;
                else
                    q = -((-num + per - 1) / per);
                n = (q < hi_n - 1) ? q : hi_n - 1;
            end
            if (n < lo_n)
                return 1'b0;
            fs = s + n * per;
            return (fs - lead <= p) && (p < fs + after);
        endfunction

        function void predict_scan(logic rs);
            strobe_t e;
            longint  p;
            longint  t;
            longint  fc;
            longint  trig_hi;
            if (rs)
                scan_cnt = '0;
            p  = longint'(scan_cnt);
            t  = longint'(cfg.total);
            fc = longint'(cfg.frame_count);
            e.lamp = 1'b0;
            e.shut = 1'b0;
            e.trig = 1'b0;
            if (p < t - 2)
            begin
                e.lamp = frame_window(p, -longint'(cfg.preheat), fc, cfsg_pkg::DEF_ILLUM_PRE,
                                      longint'(cfg.active) + cfsg_pkg::DEF_ILLUM_POST);
                e.shut = frame_window(p, 0, fc, cfsg_pkg::DEF_SHUTTER_PRE,
                                      longint'(cfg.active) + cfsg_pkg::DEF_SHUTTER_POST);
            end
            trig_hi = cfg.trig_each ? fc : ((fc < 1) ? fc : 1);
            if (p < t)
                e.trig = frame_window(p, 0, trig_hi, 0, cfsg_pkg::DEF_TRIG_WIDTH);
            e.pos  = scan_cnt;
            e.done = (p >= t);
            expected_strobes.push_back(e);
            scan_cnt = scan_cnt + 1'b1;
        endfunction

        function void check_result(strobe_t got);
            strobe_t want;
            if (expected_strobes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result beat with nothing expected, pos=%0d", got.pos);
                return;
            end
            want = expected_strobes.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: pos exp %0d got %0d | lamp %b/%b shut %b/%b",
                              " trig %b/%b done %b/%b"},
                             want.pos, got.pos, want.lamp, got.lamp, want.shut, got.shut,
                             want.trig, got.trig, want.done, got.done);
            end
        endfunction

        function int pending();
            return expected_strobes.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [cfsg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cfsg_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            item_valid;
    logic                            item_stall;
    logic                            restart;
    logic                            result_valid;
    logic                            result_stall;
    logic                            lamp_on;
    logic                            shutter_open;
    logic                            trigger_high;
    logic [cfsg_pkg::SCAN_W-1:0]     scan_position;
    logic                            record_done;

    strobe_scoreboard sb = new();
    bit               idle_on;
    int               sent;

    camera_frame_strobe_generator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .restart      (restart),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .lamp_on      (lamp_on),
        .shutter_open (shutter_open),
        .trigger_high (trigger_high),
        .scan_position(scan_position),
        .record_done  (record_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stall bursts.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 6) == 0)
            begin
                result_stall = 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                result_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result('{lamp_on, shutter_open, trigger_high, scan_position, record_done});
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_beat(input logic rs);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        item_valid = 1'b1;
        restart    = rs;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.predict_scan(rs);
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [cfsg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cfsg_pkg::CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, data);
        // let the frame solver start, then wait for it to finish
        repeat (2) @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_cfg(input cfsg_pkg::cfg_t c, input bit write_all);
        wait_drained();
        repeat (2) @(negedge clk);
        if (write_all || $urandom_range(0, 2) != 0)
            write_reg(cfsg_pkg::REG_START, c.start);
        if (write_all || $urandom_range(0, 2) != 0)
            write_reg(cfsg_pkg::REG_PERIOD, c.period);
        if (write_all || $urandom_range(0, 2) != 0)
            write_reg(cfsg_pkg::REG_ACTIVE, c.active);
        if (write_all || $urandom_range(0, 2) != 0)
            write_reg(cfsg_pkg::REG_FCOUNT, {8'($urandom), c.frame_count});
        if (write_all || $urandom_range(0, 2) != 0)
            write_reg(cfsg_pkg::REG_PREHEAT, {16'($urandom), c.preheat});
        if (write_all || $urandom_range(0, 2) != 0)
            write_reg(cfsg_pkg::REG_TRIGEA, {23'($urandom), c.trig_each});
        if (write_all || $urandom_range(0, 2) != 0)
            write_reg(cfsg_pkg::REG_TOTAL, c.total);
        // unused index: must change nothing
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, 24'($urandom));
    endtask

    function automatic logic [23:0] pick_edge(logic [23:0] hi);
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return hi;
            default: return 24'($urandom) & hi;
        endcase
    endfunction

    initial
    begin
        cfsg_pkg::cfg_t c;
        int   n;
        int   phase;
        bit   drained_once;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        item_valid = 1'b0;
        restart    = 1'b0;
        idle_on    = 1'b0;
        sent       = 0;
        drained_once = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset configuration: empty record, everything low
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b0);

        // two preheat frames, three real frames, trigger on frame zero only
        c.start       = 24'd15;
        c.period      = 24'd25;
        c.active      = 24'd3;
        c.frame_count = 16'd3;
        c.preheat     = 8'd2;
        c.trig_each   = 1'b0;
        c.total       = 24'd110;
        apply_cfg(c, 1'b1);
        for (int i = 0; i < 22; i++)
            send_beat(i == 0 || i == 19);

        phase = 0;
        while (sent < 950)
        begin
            if (phase == 0)
            begin
                // all registers at their low end, period zero included
                c = '0;
            end
            else if (phase == 1)
            begin
                c.start       = '1;
                c.period      = '1;
                c.active      = '1;
                c.frame_count = '1;
                c.preheat     = '1;
                c.trig_each   = 1'b1;
                c.total       = '1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                c.start       = pick_edge('1);
                c.period      = pick_edge('1);
                c.active      = pick_edge('1);
                c.frame_count = 16'(pick_edge(24'hFFFF));
                c.preheat     = 8'(pick_edge(24'hFF));
                c.trig_each   = 1'($urandom);
                c.total       = pick_edge('1);
            end
            else
            begin
                c.start       = 24'($urandom_range(0, 80));
                c.period      = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom_range(1, 60));
                c.active      = 24'($urandom_range(0, 40));
                c.frame_count = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                            : 16'($urandom_range(0, 8));
                c.preheat     = 8'($urandom_range(0, 4));
                c.trig_each   = 1'($urandom);
                c.total       = 24'($urandom_range(0, 200));
            end
            idle_on = 1'b0;
            apply_cfg(c, phase < 2);
            idle_on = (sent < 800) && ($urandom_range(0, 3) != 0);
            n = $urandom_range(20, 80);
            for (int i = 0; i < n; i++)
            begin
                if (!drained_once && phase == 3 && i == n / 2)
                begin
                    // sender holds off until the pipe is empty
                    wait_drained();
                    drained_once = 1'b1;
                end
                send_beat((i == 0) ? 1'($urandom) : ($urandom_range(0, 63) == 0));
            end
            phase++;
        end

        wait_drained();
        repeat (5) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
